// ----- rtl/core/accel_axis_self_test_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the axis self-test sequencer
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ACCEL_AXIS_SELF_TEST_SEQUENCER_MACROS_SVH
`define ACCEL_AXIS_SELF_TEST_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define AXST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AXST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/axst_pkg.sv -----
// ----------------------------------------------------------------------------
// Axis self-test sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package axst_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 5;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SMP_W   = 12;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned WIN_W   = 13;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned HELD_W  = 3;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;
  // Difference of the mean and the baseline, with sign.
  localparam int unsigned DIFF_W  = SUM_W + 2;

  localparam logic [TIME_W-1:0] SETTLE_MS = TIME_W'(100);

  localparam logic mode_poll  = 1'b0;
  localparam logic MODE_RESET = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [WIN_W-1:0] X_MIN_RST = -13'sd600;
  localparam logic signed [WIN_W-1:0] X_MAX_RST = -13'sd150;
  localparam logic signed [WIN_W-1:0] Y_MIN_RST = 13'sd150;
  localparam logic signed [WIN_W-1:0] Y_MAX_RST = 13'sd600;
  localparam logic signed [WIN_W-1:0] Z_MIN_RST = 13'sd250;
  localparam logic signed [WIN_W-1:0] Z_MAX_RST = 13'sd900;
  localparam logic [IVL_W-1:0]        IVL_RST   = 16'd500;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SAMPLING = 2'd1,
    PH_DONE     = 2'd2
  } phase_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_X_MAX    = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_Y_MAX    = 3'd3,
    CFG_Z_MIN    = 3'd4,
    CFG_Z_MAX    = 3'd5,
    CFG_INTERVAL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WIN_W-1:0] x_min;
    logic signed [WIN_W-1:0] x_max;
    logic signed [WIN_W-1:0] y_min;
    logic signed [WIN_W-1:0] y_max;
    logic signed [WIN_W-1:0] z_min;
    logic signed [WIN_W-1:0] z_max;
    logic [IVL_W-1:0]        interval;
  } cfg_t;

  typedef struct packed {
    logic              axis_ok;
    logic              test_done;
    logic              self_test_on;
    logic [HELD_W-1:0] samples_held;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/accel_axis_self_test_sequencer.sv -----
// ----------------------------------------------------------------------------
// Accelerometer axis self-test sequencer
// Baseline, self-test drive, interval sampling and window verdict for one
// accelerometer axis, one status result per poll or reset item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns exactly one result
// for each, at the earliest in the cycle after the item is accepted, and later
// while the result side holds off. The whole update of the
// test state for an item (interval check, accumulate, mean by a constant
// reciprocal multiply, window compare) sits between the state registers and
// a two-entry output buffer, so items may arrive back to back; in_ready_o
// drops only when both output entries hold results not yet taken.
// Configuration writes are accepted in every cycle and should be issued only
// while no item is in flight.
`default_nettype none

module accel_axis_self_test_sequencer #(
  parameter int unsigned SAMPLE_COUNT = axst_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [axst_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [axst_pkg::AXIS_W-1:0]   axis_i,
  input  logic [axst_pkg::SMP_W-1:0]    sample_mv_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          axis_ok_o,
  output logic                          test_done_o,
  output logic                          self_test_on_o,
  output logic [axst_pkg::HELD_W-1:0]   samples_held_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [axst_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [axst_pkg::CDATA_W-1:0]  cfg_data_i
);

  axst_pkg::cfg_t    cfg_q, cfg_d;
  axst_pkg::result_t step_res;
  axst_pkg::result_t out_res;
  logic              in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (axst_pkg::cfg_idx_e'(cfg_index_i))
        axst_pkg::CFG_X_MIN:    cfg_d.x_min    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_X_MAX:    cfg_d.x_max    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_Y_MIN:    cfg_d.y_min    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_Y_MAX:    cfg_d.y_max    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_Z_MIN:    cfg_d.z_min    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_Z_MAX:    cfg_d.z_max    = cfg_data_i[axst_pkg::WIN_W-1:0];
        axst_pkg::CFG_INTERVAL: cfg_d.interval = cfg_data_i[axst_pkg::IVL_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min    <= axst_pkg::X_MIN_RST;
      cfg_q.x_max    <= axst_pkg::X_MAX_RST;
      cfg_q.y_min    <= axst_pkg::Y_MIN_RST;
      cfg_q.y_max    <= axst_pkg::Y_MAX_RST;
      cfg_q.z_min    <= axst_pkg::Z_MIN_RST;
      cfg_q.z_max    <= axst_pkg::Z_MAX_RST;
      cfg_q.interval <= axst_pkg::IVL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  axst_step #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .mode_i      (mode_i),
    .now_ms_i    (now_ms_i),
    .axis_i      (axis_i),
    .sample_mv_i (sample_mv_i),
    .cfg_i       (cfg_q),
    .res_o       (step_res)
  );

  axst_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (step_res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign axis_ok_o      = out_res.axis_ok;
  assign test_done_o    = out_res.test_done;
  assign self_test_on_o = out_res.self_test_on;
  assign samples_held_o = out_res.samples_held;

endmodule

`default_nettype wire

// ----- rtl/core/axst_step.sv -----
// ----------------------------------------------------------------------------
// Axis self-test step logic
// Holds the test state and applies one accepted item to it per cycle,
// producing the status that follows the update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_axis_self_test_sequencer_macros.svh"

module axst_step #(
  parameter int unsigned SAMPLE_COUNT = axst_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             mode_i,
  input  logic [axst_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [axst_pkg::AXIS_W-1:0]      axis_i,
  input  logic [axst_pkg::SMP_W-1:0]       sample_mv_i,
  input  axst_pkg::cfg_t                   cfg_i,
  output axst_pkg::result_t                res_o
);

  localparam int unsigned CNT_W   = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned SHIFT   = axst_pkg::SUM_W + $clog2(SAMPLE_COUNT);
  localparam int unsigned PROD_W  = SHIFT + axst_pkg::SUM_W;
  // Reciprocal of the sample count, rounded up; exact for every sum that fits.
  localparam logic [PROD_W-1:0] MEAN_MUL =
    PROD_W'(((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_COUNT);

  axst_pkg::phase_e                  phase_q, phase_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [axst_pkg::TIME_W-1:0]       last_q, last_d;
  logic [axst_pkg::SMP_W-1:0]        base_q, base_d;
  logic [axst_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic                              pass_q, pass_d;

  logic [axst_pkg::TIME_W-1:0]       elapsed;
  logic                              due;
  logic [PROD_W-1:0]                 prod;
  logic [axst_pkg::SUM_W-1:0]        mean;
  logic signed [axst_pkg::DIFF_W-1:0] mean_s;
  logic signed [axst_pkg::DIFF_W-1:0] base_s;
  logic signed [axst_pkg::DIFF_W-1:0] diff;
  logic signed [axst_pkg::DIFF_W-1:0] lo;
  logic signed [axst_pkg::DIFF_W-1:0] hi;
  logic                              axis_valid;
  logic                              in_window;

  assign elapsed = now_ms_i - last_q;
  assign due     = elapsed >= axst_pkg::TIME_W'(cfg_i.interval);

  assign prod   = PROD_W'(sum_q) * MEAN_MUL;
  assign mean   = prod[SHIFT +: axst_pkg::SUM_W];
  assign mean_s = axst_pkg::DIFF_W'(mean);
  assign base_s = axst_pkg::DIFF_W'(base_q);
  assign diff   = mean_s - base_s;

  always_comb begin
    lo         = '0;
    hi         = '0;
    axis_valid = 1'b1;
    unique case (axis_i)
      axst_pkg::AXIS_X: begin
        lo = axst_pkg::DIFF_W'(cfg_i.x_min);
        hi = axst_pkg::DIFF_W'(cfg_i.x_max);
      end
      axst_pkg::AXIS_Y: begin
        lo = axst_pkg::DIFF_W'(cfg_i.y_min);
        hi = axst_pkg::DIFF_W'(cfg_i.y_max);
      end
      axst_pkg::AXIS_Z: begin
        lo = axst_pkg::DIFF_W'(cfg_i.z_min);
        hi = axst_pkg::DIFF_W'(cfg_i.z_max);
      end
      default: begin
        axis_valid = 1'b0;
      end
    endcase
  end

  assign in_window = axis_valid && (diff >= lo) && (diff <= hi);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    last_d  = last_q;
    base_d  = base_q;
    sum_d   = sum_q;
    pass_d  = pass_q;
    if (accept_i) begin
      if (mode_i == axst_pkg::MODE_RESET) begin
        phase_d = axst_pkg::PH_IDLE;
        count_d = '0;
        last_d  = '0;
        base_d  = '0;
        sum_d   = '0;
        pass_d  = 1'b0;
      end else begin
        unique case (phase_q)
          axst_pkg::PH_SAMPLING: begin
            if (count_q < CNT_FULL) begin
              if (due) begin
                sum_d   = sum_q + axst_pkg::SUM_W'(sample_mv_i);
                count_d = count_q + CNT_W'(1);
                last_d  = now_ms_i;
              end
            end else begin
              pass_d  = in_window;
              count_d = '0;
              phase_d = axst_pkg::PH_DONE;
            end
          end
          axst_pkg::PH_DONE: begin
            phase_d = axst_pkg::PH_DONE;
          end
          default: begin
            // Idle, and the unused phase code, start a new run.
            base_d  = sample_mv_i;
            sum_d   = '0;
            count_d = '0;
            last_d  = now_ms_i + axst_pkg::SETTLE_MS;
            phase_d = axst_pkg::PH_SAMPLING;
          end
        endcase
      end
    end
  end

  // Outputs follow the updated state.
  always_comb begin
    res_o.axis_ok      = pass_d;
    res_o.test_done    = (phase_d == axst_pkg::PH_DONE);
    res_o.self_test_on = (phase_d == axst_pkg::PH_SAMPLING);
    res_o.samples_held = axst_pkg::HELD_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= axst_pkg::PH_IDLE;
      count_q <= '0;
      last_q  <= '0;
      base_q  <= '0;
      sum_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      last_q  <= last_d;
      base_q  <= base_d;
      sum_q   <= sum_d;
      pass_q  <= pass_d;
    end
  end

  `AXST_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CNT_FULL, "sample count overran")
  `AXST_ASSERT_NOW(a_idle_clear, clk_i, rst_ni, phase_q == axst_pkg::PH_IDLE, (sum_q == '0) && (count_q == '0) && !pass_q, "idle with stale state")
  `AXST_ASSERT_NOW(a_done_count, clk_i, rst_ni, phase_q == axst_pkg::PH_DONE, count_q == '0, "verdict held with samples")
  `AXST_ASSERT_NEXT(a_reset_item, clk_i, rst_ni, accept_i && (mode_i == axst_pkg::MODE_RESET), (phase_q == axst_pkg::PH_IDLE) && (last_q == '0), "reset item did not clear")
  `AXST_ASSERT_NEXT(a_start, clk_i, rst_ni, accept_i && (mode_i == axst_pkg::mode_poll) && (phase_q == axst_pkg::PH_IDLE), (phase_q == axst_pkg::PH_SAMPLING) && (count_q == '0), "start poll did not begin sampling")

endmodule

`default_nettype wire

// ----- rtl/core/axst_out_buf.sv -----
// ----------------------------------------------------------------------------
// Axis self-test result buffer
// Two-entry output stage: a result register plus a skid register, so the
// input side sees a registered ready, held low only while the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none

module axst_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  axst_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output axst_pkg::result_t data_o
);

  logic              main_vld_q, main_vld_d;
  logic              skid_vld_q, skid_vld_d;
  axst_pkg::result_t main_q, main_d;
  axst_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop     = main_vld_q && ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      // No push can arrive while the skid entry is full.
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire
